[hdl/aes_block_cipher_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef AES_BLOCK_CIPHER_TOP_DEFINES_SVH
`define AES_BLOCK_CIPHER_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hdl/aes_pkg.sv]
// Shared types, constants and byte functions for the AES block cipher.
package aes_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_IS_256 = 3'd4;

    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic       exp_start;    // load key words 0..7 (0..3 for AES-128) into the expansion window
        logic       exp_step;     // write one store word: a key word or a newly expanded one
        logic       load;         // load block into the state register
        logic       key_add;      // apply the first round key
        logic       round;        // apply one middle round
        logic       last;         // apply the final round
        logic       out_load;     // move the state to the output register
        logic [5:0] rk_addr;      // round key word base address (word index)
        logic [5:0] exp_idx;      // word index being expanded
        logic       dec;          // decrypt direction
    } aes_cmd_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
        return t[x];
    endfunction

    function automatic logic [7:0] sbox_rev(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        return t[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

    // Forward column mix of one column, byte 0 in the top bits.
    function automatic logic [31:0] mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        return {xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3,
                a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3,
                a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3,
                xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3)};
    endfunction

    // Inverse column mix: preprocess then forward mix.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a0, a1, a2, a3, u, v;
        a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
        u = xt(xt(a0 ^ a2));
        v = xt(xt(a1 ^ a3));
        return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
    endfunction

endpackage

[hdl/aes_block_cipher_top.sv]
// Top level of the AES-128/256 single-block cipher.
//   channel  direction  handshake                 payload
//   s_axis   in         s_axis_tvalid/tready      tuser opcode, tdata block
//   m_axis   out        m_axis_tvalid/tready      tdata result
//   cfg      in         cfg_valid/cfg_ready       cfg_index, cfg_data
// An item runs through load, first key, one round per cycle, final round and
// output; the next item is accepted only once its result has been moved to the
// output register.
// After reset or a key write the first item first runs key expansion, one store
// word per cycle, 44 words for AES-128 and 60 for AES-256.
// Reset clears control state; the key store is rebuilt before first use.
// A result waiting on m_axis holds the next item at its output step.
module aes_block_cipher_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // block_high [63:0], block_low [127:64]
    input  logic         s_axis_tuser,  // opcode [0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,  // result_high [63:0], result_low [127:64]
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    logic [63:0]       kw_reg [0:3];
    logic              k256_reg;
    logic              stale;
    logic [127:0]      out_block;
    aes_pkg::aes_cmd_t cmd;

    assign cfg_ready = 1'b1;
    assign stale = cfg_valid && cfg_index <= aes_pkg::REG_KEY_IS_256;

    // Hold the key registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                kw_reg[i] <= '0;
            end
            k256_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                aes_pkg::REG_KEY_WORD_0: kw_reg[0] <= cfg_data;
                aes_pkg::REG_KEY_WORD_1: kw_reg[1] <= cfg_data;
                aes_pkg::REG_KEY_WORD_2: kw_reg[2] <= cfg_data;
                aes_pkg::REG_KEY_WORD_3: kw_reg[3] <= cfg_data;
                aes_pkg::REG_KEY_IS_256: k256_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aes_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_op(s_axis_tuser),
        .key_is_256(k256_reg), .stale(stale),
        .in_ready(s_axis_tready), .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready), .cmd(cmd)
    );

    aes_datapath u_dp (
        .clk(clk), .cmd(cmd),
        .key({kw_reg[0], kw_reg[1], kw_reg[2], kw_reg[3]}),
        .key_is_256(k256_reg),
        .in_block({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .out_block(out_block)
    );

    assign m_axis_tdata = {out_block[63:0], out_block[127:64]};
endmodule

[hdl/aes_ram.sv]
// Generic single-port-write, registered-read RAM.
module aes_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [0:DEPTH-1];

    // Write and read, read data registered.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[hdl/aes_datapath.sv]
// Key expansion, round key store and round datapath.
module aes_datapath (
    input  logic             clk,
    input  aes_pkg::aes_cmd_t cmd,
    input  logic [255:0]     key,
    input  logic             key_is_256,
    input  logic [127:0]     in_block,
    output logic [127:0]     out_block
);
    logic [31:0]  win_reg [0:7];
    logic [7:0]   rc_reg;
    logic [31:0]  wnew;
    logic [31:0]  tmp;
    logic [127:0] rk;
    logic [127:0] st_reg;
    logic [127:0] sr;
    logic [127:0] mx;
    logic [127:0] sub_in;
    logic [2:0]   nk_mod;
    logic         ram_we;
    logic [5:0]   ram_waddr;
    logic [31:0]  ram_wdata;
    logic [31:0]  rdata [0:3];
    logic         k256;

    assign k256 = key_is_256;

    // Next expanded word from the sliding window of the last nk words.
    always_comb
    begin
        tmp = win_reg[7];
        nk_mod = k256 ? cmd.exp_idx[2:0] : {1'b0, cmd.exp_idx[1:0]};
        if (nk_mod == 3'd0)
        begin
            tmp = aes_pkg::sub_word({tmp[23:0], tmp[31:24]}) ^ {rc_reg, 24'h0};
        end
        else if (k256 && nk_mod == 3'd4)
        begin
            tmp = aes_pkg::sub_word(tmp);
        end
        wnew = (k256 ? win_reg[0] : win_reg[4]) ^ tmp;
    end

    // Write key words into the store: the initial words come straight from the key.
    always_comb
    begin
        ram_we = cmd.exp_step;
        ram_waddr = cmd.exp_idx;
        if (cmd.exp_idx < 6'd8 && (k256 || cmd.exp_idx < 6'd4))
        begin
            ram_wdata = key[255 - 32*cmd.exp_idx[2:0] -: 32];
        end
        else
        begin
            ram_wdata = wnew;
        end
    end

    // Shift the expansion window.
    always_ff @(posedge clk)
    begin
        if (cmd.exp_start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                win_reg[i] <= key_is_256 ? key[255 - 32*i -: 32]
                            : (i >= 4 ? key[255 - 32*(i-4) -: 32] : 32'h0);
            end
            rc_reg <= 8'h01;
        end
        else if (cmd.exp_step && !(cmd.exp_idx < 6'd8 && (k256 || cmd.exp_idx < 6'd4)))
        begin
            for (int i = 0; i < 7; i++)
            begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[7] <= wnew;
            if (nk_mod == 3'd0)
            begin
                rc_reg <= aes_pkg::xt(rc_reg);
            end
        end
    end

    // Four banks so all four words of a round key are read together.
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        aes_ram #(.WIDTH(32), .DEPTH(16)) u_ram (
            .clk  (clk),
            .we   (ram_we && ram_waddr[1:0] == 2'(b)),
            .waddr(ram_waddr[5:2]),
            .wdata(ram_wdata),
            .raddr(cmd.rk_addr[5:2]),
            .rdata(rdata[b])
        );
    end
    assign rk = {rdata[0], rdata[1], rdata[2], rdata[3]};

    // Shift rows, substitute bytes, mix columns and add the key, per direction.
    always_comb
    begin
        sub_in = st_reg;
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                if (cmd.dec)
                begin
                    sr[127 - 8*(4*c+r) -: 8] =
                        aes_pkg::sbox_rev(sub_in[127 - 8*(4*((c-r+4)%4)+r) -: 8]);
                end
                else
                begin
                    sr[127 - 8*(4*c+r) -: 8] =
                        aes_pkg::sbox(sub_in[127 - 8*(4*((c+r)%4)+r) -: 8]);
                end
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            if (cmd.dec)
            begin
                mx[127 - 32*c -: 32] = aes_pkg::inv_mix_col(sr[127 - 32*c -: 32] ^ rk[127 - 32*c -: 32]);
            end
            else
            begin
                mx[127 - 32*c -: 32] = aes_pkg::mix_col(sr[127 - 32*c -: 32]) ^ rk[127 - 32*c -: 32];
            end
        end
    end

    // Load the input block, advance the cipher state, or move it to the output register.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            st_reg <= in_block;
        end
        else if (cmd.round)
        begin
            st_reg <= mx;
        end
        else if (cmd.last)
        begin
            st_reg <= sr ^ rk;
        end
        else if (cmd.out_load)
        begin
            out_block <= st_reg;
        end
        else if (cmd.key_add)
        begin
            st_reg <= st_reg ^ rk;
        end
    end
endmodule

[hdl/aes_ctrl.sv]
// Controller sequencing key expansion, rounds and the result handshake.
module aes_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_op,
    input  logic              key_is_256,
    input  logic              stale,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output aes_pkg::aes_cmd_t cmd
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXP   = 6'b000010,
        S_KEY0  = 6'b000100,
        S_ROUND = 6'b001000,
        S_LAST  = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    state_t     state_reg, state_next;
    logic [5:0] idx_reg, idx_next;
    logic [3:0] rnd_reg, rnd_next;
    logic       dec_reg, dec_next;
    logic       exp_reg, exp_next;
    logic       ov_reg, ov_next;
    logic [3:0] nr;
    logic [3:0] rk_round;

    assign nr = key_is_256 ? 4'd14 : 4'd10;
    assign out_valid = ov_reg;
    assign in_ready = (state_reg == S_IDLE);

    // Sequence one item: optional expansion, key prefetch, rounds, output.
    always_comb
    begin
        state_next = state_reg;
        idx_next = idx_reg;
        rnd_next = rnd_reg;
        dec_next = dec_reg;
        exp_next = exp_reg && !stale;
        ov_next = ov_reg && !out_ready;
        cmd = '0;
        cmd.dec = dec_reg;
        cmd.exp_idx = idx_reg;
        rk_round = 4'd0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    dec_next = (in_op == aes_pkg::OP_DECRYPT);
                    cmd.load = 1'b1;
                    rnd_next = 4'd0;
                    if (!exp_next)
                    begin
                        cmd.exp_start = 1'b1;
                        idx_next = 6'd0;
                        state_next = S_EXP;
                    end
                    else
                    begin
                        state_next = S_KEY0;
                    end
                end
            end
            S_EXP:
            begin
                cmd.exp_step = 1'b1;
                idx_next = idx_reg + 6'd1;
                if (idx_reg == (key_is_256 ? 6'd59 : 6'd43))
                begin
                    exp_next = 1'b1;
                    state_next = S_KEY0;
                end
            end
            S_KEY0:
            begin
                // Prefetch the first round key.
                rk_round = dec_reg ? nr : 4'd0;
                rnd_next = 4'd1;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                // Use the key fetched last cycle, fetch the next one.
                rk_round = dec_reg ? nr - rnd_reg : rnd_reg;
                if (rnd_reg == 4'd1)
                begin
                    cmd.key_add = 1'b1;
                end
                else
                begin
                    cmd.round = 1'b1;
                end
                rnd_next = rnd_reg + 4'd1;
                if (rnd_reg == nr)
                begin
                    state_next = S_LAST;
                end
            end
            S_LAST:
            begin
                cmd.last = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // Hold here while the previous result is still waiting.
                if (!ov_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        cmd.rk_addr = {rk_round, 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg <= '0;
            rnd_reg <= '0;
            dec_reg <= 1'b0;
            exp_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg <= idx_next;
            rnd_reg <= rnd_next;
            dec_reg <= dec_next;
            exp_reg <= exp_next;
            ov_reg <= ov_next;
        end
    end
endmodule

[hdl/aes_checker.sv]
// Port-level checker for the AES block cipher, bound to the top level.
`include "aes_block_cipher_top_defines.svh"
module aes_checker (
    input logic clk,
    input logic rst_n,
    input logic s_axis_tvalid,
    input logic s_axis_tready,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    `AES_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `AES_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
    `AES_ASSERT_NEXT(a_no_early_result, clk, rst_n, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result appeared too early")
endmodule

bind aes_block_cipher_top aes_checker u_chk (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
